### hw/rtl/plse_pkg.sv
// plse_pkg: shared constants, control structs and helpers for the
// parallel led strip bit encoder; no dependencies
package plse_pkg;

    localparam int NUM_SLOTS    = 24;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int COL_W        = 24;
    localparam int PIN_W        = 16;
    localparam int LEN_W        = 9;
    localparam int POS_W        = LEN_W;
    localparam int CHAINS_MAX   = 4;
    localparam int CHAINS_DEF   = 4;
    localparam int IDX_W        = 4;
    localparam int CFG_W        = 16;

    localparam int unsigned LEN_MAX = 256;

    // register map
    localparam logic [IDX_W-1:0] REG_PINS_BASE = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_LEN_BASE  = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_END       = IDX_W'(8);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

    // sequencer to cell row
    typedef struct packed {
        logic             load;
        logic             shift;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

    // sequencer to output register
    typedef struct packed {
        logic emit;
        logic last_led;
        logic last_frame;
    } t_word_ctl;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (32'(v) > LEN_MAX) begin
            r = LEN_W'(LEN_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### hw/rtl/plse_if.sv
// plse_if: valid/ready channel interfaces for led positions, result words
// and register writes; depends on plse_pkg
interface plse_pix_if
    import plse_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] colour_a;
    logic [COL_W-1:0] colour_b;
    logic [COL_W-1:0] colour_c;
    logic [COL_W-1:0] colour_d;

    modport source (output valid, colour_a, colour_b, colour_c, colour_d, input ready);
    modport sink   (input valid, colour_a, colour_b, colour_c, colour_d, output ready);
endinterface

interface plse_word_if
    import plse_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] low_early_mask;
    logic             last_of_led;
    logic             last_of_frame;

    modport source (output valid, low_early_mask, last_of_led, last_of_frame, input ready);
    modport sink   (input valid, low_early_mask, last_of_led, last_of_frame, output ready);
endinterface

interface plse_cfg_if
    import plse_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/plse_cell.sv
// plse_cell: one chain of the row; shifts its colour out msb first and, on a zero
// bit or past its end, ors its pin mask into the row's word; depends on plse_pkg
module plse_cell
    import plse_pkg::*;
(
    input  logic             i_clk,
    input  logic [COL_W-1:0] i_colour,
    input  logic [PIN_W-1:0] i_pins,
    input  logic [LEN_W-1:0] i_len,
    input  t_cell_ctl        i_ctl,
    input  logic [PIN_W-1:0] i_mask,
    output logic [PIN_W-1:0] o_mask
);

    logic [COL_W-1:0] r_colour;
    logic             r_past;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_colour <= i_colour;
            r_past   <= (i_ctl.pos >= i_len);
        end else if (i_ctl.shift) begin
            r_colour <= {r_colour[COL_W-2:0], 1'b0};
        end
    end

    // chain past its end drives low for the whole led
    assign o_mask = (r_past || !r_colour[COL_W-1]) ? (i_mask | i_pins) : i_mask;

endmodule

### hw/rtl/plse_seq.sv
// plse_seq: bit slot counter, led position and input handshake for the
// cell row; depends on plse_pkg
module plse_seq
    import plse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_free,
    input  logic [LEN_W-1:0] i_frame_len,
    output logic             o_in_ready,
    output t_cell_ctl        o_ctl,
    output t_word_ctl        o_word
);

    logic              r_busy, n_busy;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_frame_end, n_frame_end;

    logic             adv, last, accept, start, frame_end;
    logic [POS_W-1:0] pos_eff;
    logic [POS_W:0]   pos_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_slot      <= '0;
            r_pos       <= '0;
            r_frame_end <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_slot      <= n_slot;
            r_pos       <= n_pos;
            r_frame_end <= n_frame_end;
        end
    end

    always_comb begin
        adv        = r_busy && i_out_free;
        last       = (r_slot == SLOT_LAST);
        o_in_ready = !r_busy || (adv && last);
        accept     = i_in_valid && o_in_ready;
        start      = accept && (i_frame_len != '0);
        // lengths lowered mid-frame restart the position
        pos_eff    = (r_pos >= i_frame_len) ? '0 : r_pos;
        pos_inc    = {1'b0, pos_eff} + (POS_W+1)'(1);
        frame_end  = (pos_inc == {1'b0, i_frame_len});

        n_busy      = r_busy;
        n_slot      = r_slot;
        n_pos       = r_pos;
        n_frame_end = r_frame_end;

        if (accept) begin
            if (i_frame_len == '0) begin
                n_pos = '0;
            end else if (frame_end) begin
                n_pos = '0;
            end else begin
                n_pos = pos_inc[POS_W-1:0];
            end
        end

        if (start) begin
            n_busy      = 1'b1;
            n_slot      = '0;
            n_frame_end = frame_end;
        end else if (adv) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_slot = r_slot + SLOT_W'(1);
            end
        end

        o_ctl.load        = start;
        o_ctl.shift       = adv;
        o_ctl.pos         = pos_eff;
        o_word.emit       = adv;
        o_word.last_led   = last;
        o_word.last_frame = last && r_frame_end;
    end

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_busy && r_slot == '0))
        else $error("led start did not load slot counter");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_out_free) |=> (r_busy && $stable(r_slot)))
        else $error("slot moved while output stalled");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_slot <= SLOT_LAST))
        else $error("slot counter out of range");

    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_frame_len == '0) |=> (r_pos == '0))
        else $error("empty frame did not clear position");

    a_no_ready_mid_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !last) |-> !o_in_ready)
        else $error("input taken in the middle of an led");

endmodule

### hw/rtl/parallel_led_strip_bit_encoder_top.sv
// parallel_led_strip_bit_encoder_top: register file, cell row, sequencer and
// output register; depends on plse_pkg, plse_if, plse_cell, plse_seq
//
//  channel  dir  payload                                       transaction
//  i_pix    in   colour_a..colour_d, 24 bits each              one led position
//  o_word   out  low_early_mask, last_of_led, last_of_frame    one bit slot word
//  i_cfg    in   index (4 bits), data (16 bits)                one register write
//
// each led position gives one word per bit slot from the slot counter, one word a cycle unless o_word stalls
// the next position is taken in the cycle of the last word
// a taken position loads the cells, and its first word then goes to the output register;
// a position with all lengths zero is taken without starting the slot counter and gives no words
// a stalled o_word holds the word and freezes the slot counter
// reset is synchronous and clears registers, position and handshake state
module parallel_led_strip_bit_encoder_top
    import plse_pkg::*;
#(
    parameter int CHAINS = CHAINS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    plse_pix_if.sink      i_pix,
    plse_word_if.source   o_word,
    plse_cfg_if.sink      i_cfg
);

    logic [PIN_W-1:0] r_pins [CHAINS_MAX];
    logic [LEN_W-1:0] r_len  [CHAINS_MAX];

    logic             r_out_valid;
    logic [PIN_W-1:0] r_mask;
    logic             r_last_led;
    logic             r_last_frame;

    logic [COL_W-1:0] w_colour [CHAINS_MAX];
    logic [PIN_W-1:0] w_mask   [CHAINS+1];
    logic [LEN_W-1:0] frame_len;
    logic             out_free;
    t_cell_ctl        cell_ctl;
    t_word_ctl        word_ctl;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHAINS_MAX; c++) begin
                r_pins[c] <= '0;
                r_len[c]  <= '0;
            end
        end else if (i_cfg.valid) begin
            if (i_cfg.index < REG_LEN_BASE) begin
                r_pins[i_cfg.index[1:0]] <= i_cfg.data;
            end else if (i_cfg.index < REG_END) begin
                r_len[i_cfg.index[1:0]] <= sat_len(i_cfg.data[LEN_W-1:0]);
            end
        end
    end

    // frame is as long as the longest active chain
    always_comb begin
        frame_len = '0;
        for (int c = 0; c < CHAINS; c++) begin
            if (r_len[c] > frame_len) begin
                frame_len = r_len[c];
            end
        end
    end

    assign w_colour[0] = i_pix.colour_a;
    assign w_colour[1] = i_pix.colour_b;
    assign w_colour[2] = i_pix.colour_c;
    assign w_colour[3] = i_pix.colour_d;

    assign out_free = !r_out_valid || o_word.ready;

    plse_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_out_free  (out_free),
        .i_frame_len (frame_len),
        .o_in_ready  (i_pix.ready),
        .o_ctl       (cell_ctl),
        .o_word      (word_ctl)
    );

    assign w_mask[0] = '0;

    for (genvar g = 0; g < CHAINS; g++) begin : g_cell
        plse_cell u_cell (
            .i_clk    (i_clk),
            .i_colour (w_colour[g]),
            .i_pins   (r_pins[g]),
            .i_len    (r_len[g]),
            .i_ctl    (cell_ctl),
            .i_mask   (w_mask[g]),
            .o_mask   (w_mask[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= word_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && word_ctl.emit) begin
            r_mask       <= w_mask[CHAINS];
            r_last_led   <= word_ctl.last_led;
            r_last_frame <= word_ctl.last_frame;
        end
    end

    assign o_word.valid          = r_out_valid;
    assign o_word.low_early_mask = r_mask;
    assign o_word.last_of_led    = r_last_led;
    assign o_word.last_of_frame  = r_last_frame;

endmodule

### tb/sv/parallel_led_strip_bit_encoder_top_tb.sv
`timescale 1ns / 1ps
// parallel_led_strip_bit_encoder_top_tb: self-checking bench for the led strip
// bit encoder, with an in-bench encoder model and a word scoreboard
// depends on plse_pkg, plse_if and parallel_led_strip_bit_encoder_top
module parallel_led_strip_bit_encoder_top_tb;
    import plse_pkg::*;

    localparam int NCH       = CHAINS_DEF;
    localparam int SETTLE    = 8;
    localparam int CYCLE_CAP = 200000;
    localparam logic [IDX_W-1:0] REG_TOP = '1;

    typedef struct packed {
        logic [COL_W-1:0] a;
        logic [COL_W-1:0] b;
        logic [COL_W-1:0] c;
        logic [COL_W-1:0] d;
    } led_t;

    typedef struct packed {
        logic [PIN_W-1:0] mask;
        logic             last_led;
        logic             last_frame;
    } word_t;

    // element 0 is chain a
    typedef logic [3:0][CFG_W-1:0] chain_set_t;

    logic i_clk;
    logic i_rst_n;

    plse_pix_if  pix_ch ();
    plse_word_if word_ch ();
    plse_cfg_if  cfg_ch ();

    parallel_led_strip_bit_encoder_top #(
        .CHAINS(NCH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch),
        .o_word (word_ch),
        .i_cfg  (cfg_ch)
    );

    led_t             led_backlog[$];
    word_t            expected_words[$];
    logic [PIN_W-1:0] pins_cfg [4];
    logic [LEN_W-1:0] len_cfg [4];
    int               led_pos;
    bit               steady;
    int               errors;
    int               leds_taken;
    int               words_seen;
    int               frames_seen;
    int               reg_writes;
    int               cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        logic [LEN_W-1:0] len;
        len = d[LEN_W-1:0];
        if (idx < REG_LEN_BASE) begin
            pins_cfg[int'(idx - REG_PINS_BASE)] = d[PIN_W-1:0];
        end else if (idx < REG_END) begin
            len_cfg[int'(idx - REG_LEN_BASE)] = (len > LEN_MAX) ? LEN_W'(LEN_MAX) : len;
        end
    endfunction

    // expected words of one led position, colour msb first
    function automatic void encode_led(input led_t px);
        logic [COL_W-1:0] col [4];
        logic [PIN_W-1:0] mask;
        word_t            w;
        int               frame_len;
        bit               frame_end;
        int               bitpos;
        col[0] = px.a;
        col[1] = px.b;
        col[2] = px.c;
        col[3] = px.d;
        frame_len = 0;
        for (int c = 0; c < NCH; c++) begin
            if (int'(len_cfg[c]) > frame_len) frame_len = int'(len_cfg[c]);
        end
        if (frame_len == 0) begin
            led_pos = 0;
            return;
        end
        // lengths lowered under the current position restart the frame
        if (led_pos >= frame_len) led_pos = 0;
        frame_end = (led_pos + 1 == frame_len);
        for (int slot = 0; slot < NUM_SLOTS; slot++) begin
            bitpos = NUM_SLOTS - 1 - slot;
            mask = '0;
            for (int c = 0; c < NCH; c++) begin
                if (led_pos >= int'(len_cfg[c]) || !col[c][bitpos]) mask |= pins_cfg[c];
            end
            w.mask       = mask;
            w.last_led   = (slot == NUM_SLOTS - 1);
            w.last_frame = (slot == NUM_SLOTS - 1) && frame_end;
            expected_words.push_back(w);
        end
        led_pos = frame_end ? 0 : led_pos + 1;
    endfunction

    function automatic logic [COL_W-1:0] random_colour();
        logic [COL_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            default: v = COL_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] random_pins();
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            default: v = CFG_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] random_len();
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 19))
            0, 1:    v = '0;
            2:       v = CFG_W'(LEN_MAX);
            3:       v = CFG_W'($urandom);
            default: v = CFG_W'($urandom_range(1, 6));
        endcase
        return v;
    endfunction

    function automatic void push_led(input logic [COL_W-1:0] a, input logic [COL_W-1:0] b,
                                     input logic [COL_W-1:0] c, input logic [COL_W-1:0] d);
        led_t px;
        px.a = a;
        px.b = b;
        px.c = c;
        px.d = d;
        led_backlog.push_back(px);
    endfunction

    function automatic void queue_random_leds(input int n);
        for (int k = 0; k < n; k++) begin
            push_led(random_colour(), random_colour(), random_colour(), random_colour());
        end
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_reg(idx, d);
        reg_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_chains(input chain_set_t pins, input chain_set_t lens);
        for (int c = 0; c < 4; c++) begin
            write_reg(REG_PINS_BASE + IDX_W'(c), pins[c]);
            write_reg(REG_LEN_BASE + IDX_W'(c), lens[c]);
        end
    endtask

    // wait until every queued led is taken and every word has come back
    task automatic drain();
        do @(posedge i_clk);
        while (led_backlog.size() != 0 || pix_ch.valid || expected_words.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : pix_driver
        led_t nxt;
        led_t seen;
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                seen = {pix_ch.colour_a, pix_ch.colour_b, pix_ch.colour_c, pix_ch.colour_d};
                encode_led(seen);
                leds_taken++;
            end
            if (!pix_ch.valid || pix_ch.ready) begin
                if (led_backlog.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
                    nxt = led_backlog.pop_front();
                    pix_ch.valid    <= 1'b1;
                    pix_ch.colour_a <= nxt.a;
                    pix_ch.colour_b <= nxt.b;
                    pix_ch.colour_c <= nxt.c;
                    pix_ch.colour_d <= nxt.d;
                end else begin
                    pix_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : word_monitor
        word_t want;
        if (!i_rst_n) begin
            word_ch.ready <= 1'b0;
        end else begin
            if (word_ch.valid && word_ch.ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected word, expected none, got mask %h led %b frame %b",
                             $time, word_ch.low_early_mask, word_ch.last_of_led,
                             word_ch.last_of_frame);
                end else begin
                    want = expected_words.pop_front();
                    if (want.last_frame) frames_seen++;
                    if (word_ch.low_early_mask !== want.mask) begin
                        errors++;
                        $display("%0t ns: low_early_mask expected %h, got %h",
                                 $time, want.mask, word_ch.low_early_mask);
                    end
                    if (word_ch.last_of_led !== want.last_led) begin
                        errors++;
                        $display("%0t ns: last_of_led expected %b, got %b",
                                 $time, want.last_led, word_ch.last_of_led);
                    end
                    if (word_ch.last_of_frame !== want.last_frame) begin
                        errors++;
                        $display("%0t ns: last_of_frame expected %b, got %b",
                                 $time, want.last_frame, word_ch.last_of_frame);
                    end
                end
            end
            word_ch.ready <= steady || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        chain_set_t pins;
        chain_set_t lens;
        i_rst_n         = 1'b0;
        pix_ch.valid    = 1'b0;
        pix_ch.colour_a = '0;
        pix_ch.colour_b = '0;
        pix_ch.colour_c = '0;
        pix_ch.colour_d = '0;
        word_ch.ready   = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        steady          = 1'b0;
        errors          = 0;
        leds_taken      = 0;
        words_seen      = 0;
        frames_seen     = 0;
        reg_writes      = 0;
        cycles          = 0;
        led_pos         = 0;
        for (int c = 0; c < 4; c++) begin
            pins_cfg[c] = '0;
            len_cfg[c]  = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: every length zero, leds give no words
        push_led('0, '0, '0, '0);
        push_led('1, '1, '1, '1);
        drain();

        // overlapping masks, chain c never active, frame of three
        program_chains({16'h8001, 16'hF000, 16'h0FF0, 16'h00FF},
                       {16'd2, 16'd0, 16'd1, 16'd3});
        push_led('0, '0, '0, '0);
        push_led('1, '1, '1, '1);
        push_led(24'hAAAAAA, 24'h555555, 24'hF0F0F0, 24'h0F0F0F);
        push_led(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h800000);
        push_led(24'h000001, 24'h800000, 24'h7FFFFE, 24'hFFFFFF);
        push_led(24'h00FF00, 24'h0000FF, 24'hFF0000, 24'h000001);
        push_led(24'h123456, 24'h89ABCD, 24'hFEDCBA, 24'h765432);
        push_led(24'h5A5A5A, 24'hA5A5A5, 24'h000000, 24'hFFFFFF);
        drain();

        // lengths lowered under the current position
        program_chains({16'h8001, 16'hF000, 16'h0FF0, 16'h00FF},
                       {16'd0, 16'd0, 16'd1, 16'd2});
        push_led(24'h0F0F0F, 24'hF0F0F0, 24'hAAAAAA, 24'h555555);
        push_led('1, '0, '1, '0);
        push_led(24'hC3C3C3, 24'h3C3C3C, 24'h999999, 24'h666666);
        drain();

        // all lengths back to zero, plus writes to unused indexes
        program_chains({16'h8001, 16'hF000, 16'h0FF0, 16'h00FF}, '0);
        write_reg(REG_END, 16'hFFFF);
        write_reg(REG_TOP, 16'hFFFF);
        push_led('1, '1, '1, '1);
        push_led(24'h800001, 24'h800001, 24'h800001, 24'h800001);
        drain();

        // saturating lengths and extreme masks
        program_chains({16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF},
                       {16'd1, 16'd257, 16'd256, 16'hFFFF});
        push_led('0, '1, '0, '1);
        push_led('1, '0, '1, '0);
        push_led(24'hAAAAAA, 24'hAAAAAA, 24'h555555, 24'h555555);
        drain();

        // a full frame of the longest chain
        for (int c = 0; c < 4; c++) pins[c] = random_pins();
        lens = {CFG_W'($urandom_range(0, 20)), CFG_W'(LEN_MAX),
                CFG_W'($urandom_range(100, 255)), 16'h01FF};
        program_chains(pins, lens);
        queue_random_leds(257);
        drain();

        for (int p = 0; p < 5; p++) begin
            for (int c = 0; c < 4; c++) begin
                pins[c] = random_pins();
                lens[c] = random_len();
            end
            program_chains(pins, lens);
            steady = (p == 1);
            if (p == 3) begin
                // sender holds off until every word is back, then resumes
                queue_random_leds(10);
                drain();
                queue_random_leds(10);
            end else begin
                queue_random_leds(20);
            end
            drain();
            steady = 1'b0;
        end

        if (expected_words.size() != 0) begin
            errors += expected_words.size();
            $display("%0t ns: %0d expected words never arrived", $time, expected_words.size());
        end
        $display("covered %0d led positions, %0d words checked, %0d frame ends",
                 leds_taken, words_seen, frames_seen);
        $display("%0d register writes over directed and random chain settings", reg_writes);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/plse_pkg.sv
hw/rtl/plse_if.sv
hw/rtl/plse_cell.sv
hw/rtl/plse_seq.sv
hw/rtl/parallel_led_strip_bit_encoder_top.sv
tb/sv/parallel_led_strip_bit_encoder_top_tb.sv
